>>> src/assert_macros.svh
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge outside reset
`define SBCT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property at every rising edge, reset included
`define SBCT_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> src/sbct_pkg.sv
package sbct_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int SHIFT_FRAC_DEF = 8;
  localparam int TIME_FRAC_DEF  = 16;

  localparam int SHIFT_W = 24;
  localparam int DIV_W   = SHIFT_W + 2;
  localparam int SIDE_W  = 3;

  localparam logic [SIDE_W-1:0] SIDE_NONE   = 3'd0;
  localparam logic [SIDE_W-1:0] SIDE_TOP    = 3'd1;
  localparam logic [SIDE_W-1:0] SIDE_BOTTOM = 3'd2;
  localparam logic [SIDE_W-1:0] SIDE_LEFT   = 3'd3;
  localparam logic [SIDE_W-1:0] SIDE_RIGHT  = 3'd4;

  typedef struct packed {
    logic gap_neg;
    logic neg;
    logic zero;
    logic sat;
  } lane_t;

  typedef struct packed {
    logic  sx_zero;
    logic  sy_zero;
    lane_t xin;
    lane_t xout;
    lane_t yin;
    lane_t yout;
  } flags_t;

  typedef struct packed {
    flags_t           flags;
    logic [DIV_W-1:0] a_xin;
    logic [DIV_W-1:0] a_xout;
    logic [DIV_W-1:0] a_yin;
    logic [DIV_W-1:0] a_yout;
    logic [DIV_W-1:0] d_x;
    logic [DIV_W-1:0] d_y;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

>>> src/swept_box_collision_time.sv
// Swept box collision time.
// Input channel: drive the box edges and displacement on the in_ ports with start
// high; the word is taken at a rising edge where start is high and busy is low.
// Result channel: out_strobe marks one cycle carrying out_entry_fraction,
// out_hit and out_struck_side; the receiver takes it at the edge ending that cycle
// and cannot stall, so results are never held.
// Path: the queue, then the per-axis divider with one quotient bit per pipeline stage,
// four dividers side by side, then the output register that drives the strobe.
// Throughput: one word per cycle; the front classifier feeds a two-entry queue
// that the back pipeline drains every cycle, so busy stays low in operation.
// Reset: synchronous, active low; clears the queue and all pipeline valid bits,
// dropping any words in flight. No configuration and no state between words.
module swept_box_collision_time #(
  parameter int COORD_BITS      = sbct_pkg::COORD_BITS_DEF,
  parameter int SHIFT_FRAC_BITS = sbct_pkg::SHIFT_FRAC_DEF,
  parameter int TIME_FRAC_BITS  = sbct_pkg::TIME_FRAC_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [COORD_BITS-1:0]        in_mover_left,
  input  logic signed [COORD_BITS-1:0]        in_mover_top,
  input  logic signed [COORD_BITS-1:0]        in_mover_right,
  input  logic signed [COORD_BITS-1:0]        in_mover_bottom,
  input  logic signed [COORD_BITS-1:0]        in_target_left,
  input  logic signed [COORD_BITS-1:0]        in_target_top,
  input  logic signed [COORD_BITS-1:0]        in_target_right,
  input  logic signed [COORD_BITS-1:0]        in_target_bottom,
  input  logic signed [sbct_pkg::SHIFT_W-1:0] in_shift_x,
  input  logic signed [sbct_pkg::SHIFT_W-1:0] in_shift_y,
  output logic                                out_strobe,
  output logic [TIME_FRAC_BITS:0]             out_entry_fraction,
  output logic                                out_hit,
  output logic [sbct_pkg::SIDE_W-1:0]         out_struck_side
);

  sbct_pkg::entry_t            front_entry;
  logic [sbct_pkg::ENTRY_W-1:0] head;
  logic                         empty, full;

  sbct_front #(
    .COORD_BITS(COORD_BITS),
    .SHIFT_FRAC_BITS(SHIFT_FRAC_BITS)
  ) u_front (
    .mover_left(in_mover_left),
    .mover_top(in_mover_top),
    .mover_right(in_mover_right),
    .mover_bottom(in_mover_bottom),
    .target_left(in_target_left),
    .target_top(in_target_top),
    .target_right(in_target_right),
    .target_bottom(in_target_bottom),
    .shift_x(in_shift_x),
    .shift_y(in_shift_y),
    .entry(front_entry)
  );

  sbct_fifo #(.W(sbct_pkg::ENTRY_W)) u_fifo (
    .clk(clk),
    .rst_n(rst_n),
    .push(start && !full),
    .din(sbct_pkg::ENTRY_W'(front_entry)),
    .pop(!empty),
    .head(head),
    .empty(empty),
    .full(full)
  );

  assign busy = full;

  sbct_back #(.TIME_FRAC_BITS(TIME_FRAC_BITS)) u_back (
    .clk(clk),
    .rst_n(rst_n),
    .valid(!empty),
    .entry(sbct_pkg::entry_t'(head)),
    .strobe(out_strobe),
    .entry_fraction(out_entry_fraction),
    .hit(out_hit),
    .struck_side(out_struck_side)
  );

endmodule

>>> src/sbct_front.sv
module sbct_front #(
  parameter int COORD_BITS      = sbct_pkg::COORD_BITS_DEF,
  parameter int SHIFT_FRAC_BITS = sbct_pkg::SHIFT_FRAC_DEF
) (
  input  logic signed [COORD_BITS-1:0]       mover_left,
  input  logic signed [COORD_BITS-1:0]       mover_top,
  input  logic signed [COORD_BITS-1:0]       mover_right,
  input  logic signed [COORD_BITS-1:0]       mover_bottom,
  input  logic signed [COORD_BITS-1:0]       target_left,
  input  logic signed [COORD_BITS-1:0]       target_top,
  input  logic signed [COORD_BITS-1:0]       target_right,
  input  logic signed [COORD_BITS-1:0]       target_bottom,
  input  logic signed [sbct_pkg::SHIFT_W-1:0] shift_x,
  input  logic signed [sbct_pkg::SHIFT_W-1:0] shift_y,
  output sbct_pkg::entry_t                   entry
);

  localparam int GW = COORD_BITS + 1;
  localparam int AW = GW + SHIFT_FRAC_BITS;
  localparam int CW = ((AW > sbct_pkg::DIV_W) ? AW : sbct_pkg::DIV_W) + 1;

  function automatic logic [AW-1:0] scaled(input logic signed [GW-1:0] gap);
    logic [GW-1:0] gabs;
    gabs = gap[GW-1] ? GW'(-gap) : GW'(gap);
    return AW'(gabs) << SHIFT_FRAC_BITS;
  endfunction

  function automatic sbct_pkg::lane_t classify(input logic signed [GW-1:0] gap,
                                               input logic s_neg,
                                               input logic [sbct_pkg::DIV_W-1:0] d);
    sbct_pkg::lane_t l;
    l.gap_neg = gap[GW-1];
    l.neg     = gap[GW-1] ^ s_neg;
    l.zero    = (gap == '0);
    l.sat     = CW'(scaled(gap)) >= CW'(d);
    return l;
  endfunction

  logic signed [GW-1:0] dx_in, dx_out, dy_in, dy_out;
  logic sx_pos, sy_pos;
  logic [sbct_pkg::SHIFT_W-1:0] sabs_x, sabs_y;
  logic [sbct_pkg::DIV_W-1:0]   d_x, d_y;

  always_comb begin
    sx_pos = !shift_x[sbct_pkg::SHIFT_W-1] && (shift_x != '0);
    sy_pos = !shift_y[sbct_pkg::SHIFT_W-1] && (shift_y != '0);
    if (sx_pos) begin
      dx_in  = GW'(target_left) - GW'(mover_right);
      dx_out = GW'(target_right) - GW'(mover_left);
    end else begin
      dx_in  = GW'(target_right) - GW'(mover_left);
      dx_out = GW'(target_left) - GW'(mover_right);
    end
    if (sy_pos) begin
      dy_in  = GW'(target_top) - GW'(mover_bottom);
      dy_out = GW'(target_bottom) - GW'(mover_top);
    end else begin
      dy_in  = GW'(target_bottom) - GW'(mover_top);
      dy_out = GW'(target_top) - GW'(mover_bottom);
    end
    sabs_x = shift_x[sbct_pkg::SHIFT_W-1] ? sbct_pkg::SHIFT_W'(-shift_x)
                                          : sbct_pkg::SHIFT_W'(shift_x);
    sabs_y = shift_y[sbct_pkg::SHIFT_W-1] ? sbct_pkg::SHIFT_W'(-shift_y)
                                          : sbct_pkg::SHIFT_W'(shift_y);
    d_x = {sabs_x, 2'b00};
    d_y = {sabs_y, 2'b00};

    entry.flags.sx_zero = (shift_x == '0);
    entry.flags.sy_zero = (shift_y == '0);
    entry.flags.xin     = classify(dx_in,  shift_x[sbct_pkg::SHIFT_W-1], d_x);
    entry.flags.xout    = classify(dx_out, shift_x[sbct_pkg::SHIFT_W-1], d_x);
    entry.flags.yin     = classify(dy_in,  shift_y[sbct_pkg::SHIFT_W-1], d_y);
    entry.flags.yout    = classify(dy_out, shift_y[sbct_pkg::SHIFT_W-1], d_y);
    entry.a_xin  = sbct_pkg::DIV_W'(scaled(dx_in));
    entry.a_xout = sbct_pkg::DIV_W'(scaled(dx_out));
    entry.a_yin  = sbct_pkg::DIV_W'(scaled(dy_in));
    entry.a_yout = sbct_pkg::DIV_W'(scaled(dy_out));
    entry.d_x    = d_x;
    entry.d_y    = d_y;
  end

endmodule

>>> src/sbct_fifo.sv
module sbct_fifo #(
  parameter int W = sbct_pkg::ENTRY_W
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] din,
  input  logic         pop,
  output logic [W-1:0] head,
  output logic         empty,
  output logic         full
);

  logic [W-1:0] mem_r [2];
  logic         wr_ptr_r, wr_ptr_nxt;
  logic         rd_ptr_r, rd_ptr_nxt;
  logic [1:0]   count_r, count_nxt;

  assign empty = (count_r == 2'd0);
  assign full  = (count_r == 2'd2);
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ (pop && !empty);
    count_nxt  = count_r + 2'(push) - 2'(pop && !empty);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

endmodule

>>> src/sbct_div.sv
module sbct_div #(
  parameter int QB = sbct_pkg::TIME_FRAC_DEF + 2
) (
  input  logic                       clk,
  input  logic [sbct_pkg::DIV_W-1:0] a,
  input  logic [sbct_pkg::DIV_W-1:0] d,
  output logic [QB-1:0]              q,
  output logic                       rem_nz
);

  localparam int DW = sbct_pkg::DIV_W;

  logic [DW-1:0] rem_r [QB+1];
  logic [DW-1:0] d_r   [QB+1];
  logic [QB-1:0] q_r   [QB+1];

  assign rem_r[0] = a;
  assign d_r[0]   = d;
  assign q_r[0]   = '0;

  for (genvar k = 0; k < QB; k++) begin : g_stage
    logic [DW:0] dbl;
    logic        ge;
    assign dbl = {rem_r[k], 1'b0};
    assign ge  = dbl >= {1'b0, d_r[k]};
    always_ff @(posedge clk) begin
      rem_r[k+1] <= ge ? DW'(dbl - {1'b0, d_r[k]}) : DW'(dbl);
      d_r[k+1]   <= d_r[k];
      q_r[k+1]   <= {q_r[k][QB-2:0], ge};
    end
  end

  assign q      = q_r[QB];
  assign rem_nz = (rem_r[QB] != '0);

endmodule

>>> src/sbct_back.sv
module sbct_back #(
  parameter int TIME_FRAC_BITS = sbct_pkg::TIME_FRAC_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        valid,
  input  sbct_pkg::entry_t            entry,
  output logic                        strobe,
  output logic [TIME_FRAC_BITS:0]     entry_fraction,
  output logic                        hit,
  output logic [sbct_pkg::SIDE_W-1:0] struck_side
);

  localparam int QB = TIME_FRAC_BITS + 2;
  localparam int TW = TIME_FRAC_BITS + 5;
  localparam logic signed [TW-1:0] T_ONE = TW'(1 << TIME_FRAC_BITS);
  localparam logic signed [TW-1:0] T_SAT = TW'(4 << TIME_FRAC_BITS);
  localparam logic signed [TW-1:0] T_INF = TW'(8 << TIME_FRAC_BITS);

  logic             vld_r [QB+1];
  sbct_pkg::flags_t flg_r [QB+1];

  assign vld_r[0] = valid;
  assign flg_r[0] = entry.flags;

  for (genvar k = 0; k < QB; k++) begin : g_meta
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else begin
        vld_r[k+1] <= vld_r[k];
      end
    end
    always_ff @(posedge clk) begin
      flg_r[k+1] <= flg_r[k];
    end
  end

  logic [QB-1:0] q_xin, q_xout, q_yin, q_yout;
  logic          nz_xin, nz_xout, nz_yin, nz_yout;

  sbct_div #(.QB(QB)) u_div_xin (.clk(clk), .a(entry.a_xin), .d(entry.d_x),
                                 .q(q_xin), .rem_nz(nz_xin));
  sbct_div #(.QB(QB)) u_div_xout (.clk(clk), .a(entry.a_xout), .d(entry.d_x),
                                  .q(q_xout), .rem_nz(nz_xout));
  sbct_div #(.QB(QB)) u_div_yin (.clk(clk), .a(entry.a_yin), .d(entry.d_y),
                                 .q(q_yin), .rem_nz(nz_yin));
  sbct_div #(.QB(QB)) u_div_yout (.clk(clk), .a(entry.a_yout), .d(entry.d_y),
                                  .q(q_yout), .rem_nz(nz_yout));

  function automatic logic signed [TW-1:0] lane_time(input sbct_pkg::lane_t l,
                                                     input logic [QB-1:0] qv,
                                                     input logic nz,
                                                     input logic axis_zero,
                                                     input logic is_in);
    logic signed [TW-1:0] t;
    if (axis_zero) begin
      t = is_in ? -T_INF : T_INF;
    end else if (l.zero) begin
      t = '0;
    end else if (l.sat) begin
      t = l.neg ? -T_SAT : T_SAT;
    end else if (l.neg) begin
      t = -(TW'(qv) + TW'(nz));
    end else begin
      t = TW'(qv);
    end
    return t;
  endfunction

  sbct_pkg::flags_t     f;
  logic signed [TW-1:0] tx_in, tx_out, ty_in, ty_out, t_in, t_out;
  logic                 miss;
  logic [sbct_pkg::SIDE_W-1:0] side;

  always_comb begin
    f      = flg_r[QB];
    tx_in  = lane_time(f.xin,  q_xin,  nz_xin,  f.sx_zero, 1'b1);
    tx_out = lane_time(f.xout, q_xout, nz_xout, f.sx_zero, 1'b0);
    ty_in  = lane_time(f.yin,  q_yin,  nz_yin,  f.sy_zero, 1'b1);
    ty_out = lane_time(f.yout, q_yout, nz_yout, f.sy_zero, 1'b0);
    t_in   = (tx_in > ty_in) ? tx_in : ty_in;
    t_out  = (tx_out < ty_out) ? tx_out : ty_out;
    miss   = (t_in > t_out) || (tx_in[TW-1] && ty_in[TW-1]) ||
             (tx_in > T_ONE) || (ty_in > T_ONE);
    if (tx_in < ty_in) begin
      side = f.yin.gap_neg ? sbct_pkg::SIDE_TOP : sbct_pkg::SIDE_BOTTOM;
    end else begin
      side = f.xin.gap_neg ? sbct_pkg::SIDE_LEFT : sbct_pkg::SIDE_RIGHT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe <= 1'b0;
    end else begin
      strobe <= vld_r[QB];
    end
  end

  always_ff @(posedge clk) begin
    if (miss) begin
      entry_fraction <= T_ONE[TIME_FRAC_BITS:0];
      hit            <= 1'b0;
      struck_side    <= sbct_pkg::SIDE_NONE;
    end else begin
      entry_fraction <= t_in[TIME_FRAC_BITS:0];
      hit            <= 1'b1;
      struck_side    <= side;
    end
  end

endmodule

>>> src/sbct_checker.sv
`include "assert_macros.svh"

module sbct_checker #(
  parameter int TIME_FRAC_BITS = sbct_pkg::TIME_FRAC_DEF
) (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        start,
  input logic                        busy,
  input logic                        out_strobe,
  input logic [TIME_FRAC_BITS:0]     out_entry_fraction,
  input logic                        out_hit,
  input logic [sbct_pkg::SIDE_W-1:0] out_struck_side
);

  localparam int LAT = TIME_FRAC_BITS + 3;
  localparam logic [TIME_FRAC_BITS:0] ONE = (TIME_FRAC_BITS+1)'(1 << TIME_FRAC_BITS);

  `SBCT_ASSERT(a_miss_shape, out_strobe && !out_hit |-> (out_struck_side == sbct_pkg::SIDE_NONE) && (out_entry_fraction == ONE), "miss word not in miss form")
  `SBCT_ASSERT(a_hit_shape, out_strobe && out_hit |-> (out_struck_side != sbct_pkg::SIDE_NONE) && (out_struck_side <= sbct_pkg::SIDE_RIGHT) && (out_entry_fraction <= ONE), "hit word out of range")
  `SBCT_ASSERT(a_latency, out_strobe |-> $past(start && !busy, LAT + 1), "result without matching accepted word")
  `SBCT_ASSERT(a_never_busy, !busy, "queue filled although back drains each cycle")
  `SBCT_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !out_strobe, "strobe right after reset")

endmodule

bind swept_box_collision_time sbct_checker #(.TIME_FRAC_BITS(TIME_FRAC_BITS)) u_sbct_checker (
  .clk(clk),
  .rst_n(rst_n),
  .start(start),
  .busy(busy),
  .out_strobe(out_strobe),
  .out_entry_fraction(out_entry_fraction),
  .out_hit(out_hit),
  .out_struck_side(out_struck_side)
);
